FILE: rtl/phu_pkg.sv
// Package for the pixel histogram unit: request codes, luma weights,
// bin selection functions and the bin update struct. No dependencies.
`default_nettype none

package phu_pkg;

    localparam int NUM_BINS = 256;
    localparam int BIN_AW   = 8;
    localparam int SAMPLE_W = 8;
    localparam int LUMA_AW  = 24;

    localparam logic [15:0] LUMA_WEIGHT_R = 16'd19595;
    localparam logic [15:0] LUMA_WEIGHT_G = 16'd38470;
    localparam logic [15:0] LUMA_WEIGHT_B = 16'd7471;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_chan;

    typedef enum logic {
        REG_CHAN_SEL  = 1'b0,
        REG_LUMA_MODE = 1'b1
    } t_reg;

    typedef struct packed {
        logic              add;
        logic              clr;
        logic [BIN_AW-1:0] addr;
    } t_bin_upd;

    function automatic logic [BIN_AW-1:0] luma_of(
        input logic [SAMPLE_W-1:0] r,
        input logic [SAMPLE_W-1:0] g,
        input logic [SAMPLE_W-1:0] b
    );
        logic [LUMA_AW-1:0] acc;
        acc = LUMA_AW'(LUMA_WEIGHT_R) * LUMA_AW'(r)
            + LUMA_AW'(LUMA_WEIGHT_G) * LUMA_AW'(g)
            + LUMA_AW'(LUMA_WEIGHT_B) * LUMA_AW'(b);
        return acc[LUMA_AW-1 -: BIN_AW];
    endfunction

    function automatic logic [BIN_AW-1:0] pick_bin(
        input logic                luma,
        input logic [1:0]          chan,
        input logic [SAMPLE_W-1:0] r,
        input logic [SAMPLE_W-1:0] g,
        input logic [SAMPLE_W-1:0] b
    );
        logic [BIN_AW-1:0] sel;
        case (chan)
            CH_RED:   sel = r;
            CH_GREEN: sel = g;
            default:  sel = b;
        endcase
        return luma ? luma_of(r, g, b) : sel;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/phu_req_if.sv
// Request channel of the pixel histogram unit: valid/ready plus the
// operation, pixel samples and bin index. No dependencies.
`default_nettype none

interface phu_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bin_index;

    modport source (output valid, operation, red, green, blue, bin_index, input ready);
    modport sink   (input valid, operation, red, green, blue, bin_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/phu_res_if.sv
// Result channel of the pixel histogram unit: valid/ready plus the bin
// count. No dependencies.
`default_nettype none

interface phu_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] bin_count;

    modport source (output valid, bin_count, input ready);
    modport sink   (input valid, bin_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/phu_count_store.sv
// Bin counter store: 256-entry memory with per-bin valid bits, registered
// read, increment and write-to-read forwarding. Depends on phu_pkg.
`default_nettype none

module phu_count_store import phu_pkg::*; #(
    parameter int BIN_COUNT_WIDTH = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic [BIN_AW-1:0]          i_rd_addr,
    input  wire t_bin_upd                   i_upd,
    output logic      [BIN_COUNT_WIDTH-1:0] o_old
);

    logic [BIN_COUNT_WIDTH-1:0] mem [NUM_BINS];
    logic [NUM_BINS-1:0]        r_valid;
    logic [BIN_COUNT_WIDTH-1:0] r_rd_data;
    logic                       r_rd_valid;
    logic                       r_fwd_hit;
    logic [BIN_COUNT_WIDTH-1:0] r_fwd_data;
    logic [BIN_COUNT_WIDTH-1:0] n_count;

    // never-written or cleared bins read as zero
    assign o_old   = r_fwd_hit ? r_fwd_data : (r_rd_valid ? r_rd_data : '0);
    assign n_count = o_old + BIN_COUNT_WIDTH'(1);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd_data  <= mem[i_rd_addr];
            r_fwd_data <= n_count;
            if (i_upd.add) begin
                mem[i_upd.addr] <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (i_adv) begin
            r_rd_valid <= r_valid[i_rd_addr] && !i_upd.clr;
            r_fwd_hit  <= i_upd.add && (i_upd.addr == i_rd_addr);
            if (i_upd.clr) begin
                r_valid <= '0;
            end else if (i_upd.add) begin
                r_valid[i_upd.addr] <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pixel_histogram_unit.sv
// Pixel histogram unit top level: request pipeline, APB registers and
// result register. Depends on phu_pkg, phu_req_if, phu_res_if, phu_count_store.
//
// Takes one request per cycle. Each request passes an input stage (bin
// selection, luma through three constant multiplies) and an update stage
// (one read-modify-write of the bin memory); a read request's count goes
// from the update stage into the result register. Back-to-back adds to
// the same bin are forwarded, so the rate is set only by the one-read,
// one-write bin memory. A clear zeroes all bins at once through
// per-bin valid bits; there is no clearing pass after reset. Only a held
// read result with the result side stalled holds up new requests.
`default_nettype none

module pixel_histogram_unit import phu_pkg::*; #(
    parameter int BIN_COUNT_WIDTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    phu_req_if.sink          i_req,
    phu_res_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [1:0]                 r_chan_sel;
    logic                       r_luma_mode;

    logic                       r_s1_valid;
    logic [1:0]                 r_s1_op;
    logic [SAMPLE_W-1:0]        r_s1_red;
    logic [SAMPLE_W-1:0]        r_s1_green;
    logic [SAMPLE_W-1:0]        r_s1_blue;
    logic [BIN_AW-1:0]          r_s1_idx;

    logic                       r_s2_valid;
    logic [1:0]                 r_s2_op;
    logic [BIN_AW-1:0]          r_s2_addr;

    logic                       r_out_valid;
    logic [7:0]                 r_out_count;

    logic                       adv;
    logic                       s2_read;
    logic [BIN_AW-1:0]          s1_addr;
    logic [BIN_COUNT_WIDTH-1:0] old_count;
    t_bin_upd                   upd;

    // APB registers
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LUMA_MODE) ? {31'd0, r_luma_mode} : {30'd0, r_chan_sel};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_sel  <= CH_RED;
            r_luma_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_CHAN_SEL:  r_chan_sel  <= pwdata[1:0];
                REG_LUMA_MODE: r_luma_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    // pipeline moves as a whole; only a read blocked at the result register stalls it
    assign s2_read     = r_s2_valid && (r_s2_op == OP_READ);
    assign adv         = !(s2_read && r_out_valid && !o_res.ready);
    assign i_req.ready = adv;

    assign s1_addr = (r_s1_op == OP_READ) ? r_s1_idx
                   : pick_bin(r_luma_mode, r_chan_sel, r_s1_red, r_s1_green, r_s1_blue);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_op    <= i_req.operation;
            r_s1_red   <= i_req.red;
            r_s1_green <= i_req.green;
            r_s1_blue  <= i_req.blue;
            r_s1_idx   <= i_req.bin_index;
            r_s2_op    <= r_s1_op;
            r_s2_addr  <= s1_addr;
        end
        if (s2_read && adv) begin
            r_out_count <= old_count[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_valid <= i_req.valid;
                r_s2_valid <= r_s1_valid;
            end
            if (s2_read && adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign upd.add  = r_s2_valid && (r_s2_op == OP_ADD);
    assign upd.clr  = r_s2_valid && (r_s2_op == OP_CLEAR);
    assign upd.addr = r_s2_addr;

    phu_count_store #(
        .BIN_COUNT_WIDTH (BIN_COUNT_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_rd_addr (s1_addr),
        .i_upd     (upd),
        .o_old     (old_count)
    );

    assign o_res.valid     = r_out_valid;
    assign o_res.bin_count = r_out_count;

endmodule

`default_nettype wire

FILE: tb/sv/phu_histogram_checker.sv
// Checker for the pixel histogram unit: watches the request, result and APB
// channels, keeps its own bin counts and compares every returned count.
// Depends on phu_pkg, phu_req_if and phu_res_if.
module phu_histogram_checker import phu_pkg::*; #(
    parameter int BIN_COUNT_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    phu_req_if          i_req,
    phu_res_if          i_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] bin;
        logic [7:0] count;
    } t_bin_read;

    logic [BIN_COUNT_WIDTH-1:0] bin_counts [NUM_BINS];
    logic [1:0]                 chan_sel = '0;
    logic                       luma_on  = 1'b0;
    t_bin_read                  pending_reads [$];
    int                         fails    = 0;
    int                         reported = 0;

    function automatic logic [7:0] select_bin(input logic [1:0] chan, input logic luma,
                                              input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        logic [31:0] weighted;
        weighted = 32'(LUMA_WEIGHT_R) * r + 32'(LUMA_WEIGHT_G) * g + 32'(LUMA_WEIGHT_B) * b;
        if (luma)
            return weighted[23:16];
        case (chan)
            CH_RED:   return r;
            CH_GREEN: return g;
            default:  return b;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_bin_read  head;
        logic [7:0] k;
        if (!i_rst_n) begin
            foreach (bin_counts[i]) bin_counts[i] = '0;
            chan_sel = '0;
            luma_on  = 1'b0;
            pending_reads.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg'(paddr[2]))
                    REG_CHAN_SEL:  chan_sel = pwdata[1:0];
                    REG_LUMA_MODE: luma_on  = pwdata[0];
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (pending_reads.size() == 0) begin
                    fails++;
                    if (reported < 10)
                        $display("unexpected result: bin_count %0d", i_res.bin_count);
                    reported++;
                end else begin
                    head = pending_reads.pop_front();
                    if (i_res.bin_count !== head.count) begin
                        fails++;
                        if (reported < 10)
                            $display("bin %0d count mismatch: expected %0d got %0d",
                                     head.bin, head.count, i_res.bin_count);
                        reported++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                case (t_op'(i_req.operation))
                    OP_ADD: begin
                        k = select_bin(chan_sel, luma_on, i_req.red, i_req.green, i_req.blue);
                        bin_counts[k] = bin_counts[k] + 1'b1;
                    end
                    OP_READ: begin
                        pending_reads.push_back('{bin: i_req.bin_index,
                                                  count: bin_counts[i_req.bin_index][7:0]});
                    end
                    OP_CLEAR: begin
                        foreach (bin_counts[i]) bin_counts[i] = '0;
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_reads.size();
    end
endmodule

FILE: tb/sv/tb_pixel_histogram_unit.sv
// Testbench top for the pixel histogram unit: clock, reset, APB register
// writes and request/result traffic with random gaps and stalls.
// Depends on phu_pkg, phu_req_if, phu_res_if, phu_histogram_checker and the RTL.
module tb_pixel_histogram_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import phu_pkg::*;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 6;
    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam logic [1:0] CH_BLUE_ALT  = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          reads_pending;
    int          cycle_cnt;
    bit          quiet = 1'b0;

    phu_req_if req_if ();
    phu_res_if res_if ();

    pixel_histogram_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    phu_histogram_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (reads_pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // result side stalls in bursts until the quiet stretch
    initial begin
        res_if.ready <= 1'b1;
        forever begin
            if (quiet) begin
                @(posedge clk);
            end else begin
                repeat ($urandom_range(1, 40)) @(posedge clk);
                if (!quiet) begin
                    res_if.ready <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge clk);
                    res_if.ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic [7:0] idx);
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.red       <= r;
        req_if.green     <= g;
        req_if.blue      <= b;
        req_if.bin_index <= idx;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    task automatic pause(input int n);
        req_if.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (reads_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg which, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // pixels drawn mostly from a small pool so that bins fill and reads hit them
    task automatic histogram_phase(input int n_items, input int pool_size, input bit grey,
                                   input t_chan focus, input int focus_pct, input int add_pct,
                                   input int clear_pct, input int gap_pct);
        logic [7:0] pool [4];
        logic [7:0] r, g, b, idx, v;
        logic [1:0] op;
        int         roll;
        foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
        for (int n = 0; n < n_items; n++) begin
            if (!quiet && $urandom_range(0, 99) < gap_pct)
                pause($urandom_range(1, 19));
            v   = pool[$urandom_range(0, pool_size - 1)];
            r   = 8'($urandom_range(0, 255));
            g   = 8'($urandom_range(0, 255));
            b   = 8'($urandom_range(0, 255));
            idx = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < focus_pct) begin
                if (grey) begin
                    r = v;
                    g = v;
                    b = v;
                end else begin
                    case (focus)
                        CH_RED:   r = v;
                        CH_GREEN: g = v;
                        default:  b = v;
                    endcase
                end
            end
            if ($urandom_range(0, 9) < 8)
                idx = v;
            roll = $urandom_range(0, 99);
            if (roll < add_pct)
                op = OP_ADD;
            else if (roll < add_pct + clear_pct)
                op = OP_CLEAR;
            else if (roll < add_pct + clear_pct + 3)
                op = OP_NONE;
            else
                op = OP_READ;
            send_request(op, r, g, b, idx);
        end
    endtask

    initial begin
        rst_n            <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.operation <= OP_ADD;
        req_if.red       <= '0;
        req_if.green     <= '0;
        req_if.blue      <= '0;
        req_if.bin_index <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: red channel counted
        send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(OP_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_ADD, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_ADD, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_request(OP_ADD, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_request(OP_NONE, 8'h80, 8'h80, 8'h80, 8'h80);
        send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_request(OP_READ, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        drain();
        write_reg(REG_LUMA_MODE, 32'h0000_0001);
        send_request(OP_ADD, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_request(OP_ADD, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(OP_ADD, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_request(OP_ADD, 8'h00, 8'hFF, 8'h00, 8'h00);
        send_request(OP_ADD, 8'h00, 8'h00, 8'hFF, 8'h00);
        send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'd29);
        send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'd76);
        send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'd149);
        send_request(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00);
        drain();
        // upper bits must be dropped; channel three counts blue
        write_reg(REG_CHAN_SEL, 32'hFFFF_FFFF);
        write_reg(REG_LUMA_MODE, 32'hFFFF_FFFE);
        send_request(OP_ADD, 8'h00, 8'h00, 8'hFF, 8'h00);
        send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'hFF);
        drain();

        // one bin hammered well past wrap
        write_reg(REG_CHAN_SEL, ($urandom & ~32'h3) | 32'(CH_BLUE_ALT));
        write_reg(REG_LUMA_MODE, $urandom & ~32'h1);
        histogram_phase(300, 1, 1'b0, CH_BLUE, 100, 93, 0, 5);
        drain();
        write_reg(REG_CHAN_SEL, 32'(CH_GREEN));
        histogram_phase(35, 4, 1'b0, CH_GREEN, 75, 60, 4, 20);
        drain();
        write_reg(REG_CHAN_SEL, 32'(CH_RED));
        write_reg(REG_LUMA_MODE, $urandom | 32'h1);
        histogram_phase(35, 4, 1'b1, CH_RED, 75, 60, 4, 20);
        drain();
        write_reg(REG_CHAN_SEL, 32'(CH_BLUE));
        write_reg(REG_LUMA_MODE, 32'h0);
        histogram_phase(35, 4, 1'b0, CH_BLUE, 75, 60, 4, 20);
        drain();
        write_reg(REG_LUMA_MODE, 32'h1);
        quiet = 1'b1;
        @(posedge clk);
        while (!res_if.ready) @(posedge clk);
        histogram_phase(35, 4, 1'b1, CH_RED, 75, 60, 4, 0);
        drain();

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/phu_pkg.sv
rtl/phu_req_if.sv
rtl/phu_res_if.sv
rtl/phu_count_store.sv
rtl/pixel_histogram_unit.sv
tb/sv/phu_histogram_checker.sv
tb/sv/tb_pixel_histogram_unit.sv
